@@ src/sflv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflv_pkg
// Shared types and constants of the spatial filter log-variance feature block.
// ----------------------------------------------------------------------------
package sflv_pkg;

  localparam int unsigned CHANNELS_DEF   = 16;
  localparam int unsigned COMPONENTS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned PROJ_W = 36;
  localparam int unsigned ENER_W = 64;
  localparam int unsigned SQ_W   = 55;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned L2_W   = 27;
  localparam int unsigned MANT_W = 31;
  localparam int unsigned FEAT_W = 48;

  localparam logic [5:0] LOG_FRAC_TOP = 6'd19;
  localparam logic signed [MUL_W-1:0] LN2_Q30 = 33'sd744261118;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_LOG    = 2'd0,
    CFG_CHANNELS   = 2'd1,
    CFG_COMPONENTS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_SQ_HH,
    ST_SQ_HL,
    ST_SQ_LL,
    ST_SQ_ADD,
    ST_ENERGY,
    ST_FEAT,
    ST_DIV,
    ST_SEL,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_LN_MUL,
    ST_LN_RND,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [3:0]         channel;
    logic [2:0]         component;
    logic signed [15:0] value;
    logic               end_of_epoch;
  } in_t;

  typedef struct packed {
    logic [2:0]                component_index;
    logic signed [FEAT_W-1:0]  feature;
    logic                      last;
  } out_t;

endpackage

@@ src/sflv_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sflv_mul (
  input  logic                                  clk_i,
  input  logic signed [sflv_pkg::MUL_W-1:0]     a_i,
  input  logic signed [sflv_pkg::MUL_W-1:0]     b_i,
  output logic signed [sflv_pkg::PROD_W-1:0]    p_o
);

  logic signed [sflv_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ src/spatial_filter_log_variance_features.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_filter_log_variance_features
// Spatial filter projection, per-step energy and per-epoch (log) variance.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  in        in_valid_i / in_ready_o / in_data_i    item in (weight or sample)
//  out       out_valid_o / out_ready_i / out_data_o feature out, one per component
//  cfg       cfg_we_i / cfg_idx_i / cfg_wdata_i     register write, one cycle
//
// A weight load leaves the block ready. A sample passes read, multiply and
// accumulate per component in use through the shared multiplier; a sample
// that closes a time step adds, per component, the three partial-product
// square, a sum and the energy update. An epoch end adds per component a
// divide (load, 64 quotient bits, select), in log mode a normalizing shift,
// squaring log2, ln scaling, and an output that holds while out_ready_i is low.
// Reset clears accumulators and step count, presets the registers; weights are not cleared.
// ----------------------------------------------------------------------------
module spatial_filter_log_variance_features #(
  parameter int unsigned CHANNELS   = sflv_pkg::CHANNELS_DEF,
  parameter int unsigned COMPONENTS = sflv_pkg::COMPONENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sflv_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sflv_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [sflv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sflv_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CW    = $clog2(CHANNELS);
  localparam int unsigned KW    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int unsigned AW    = KW + CW;
  localparam int unsigned DEPTH = COMPONENTS << CW;

  localparam int unsigned PW = sflv_pkg::PROJ_W;
  localparam int unsigned EW = sflv_pkg::ENER_W;
  localparam int unsigned MW = sflv_pkg::MUL_W;

  sflv_pkg::state_e state_q, state_d;

  // configuration
  logic       use_log_q;
  logic [4:0] ch_use_q;
  logic [3:0] comp_use_q;
  logic [6:0] nch;
  logic [4:0] ncomp;

  // accumulators
  logic signed [PW-1:0]           proj_q   [COMPONENTS];
  logic [EW-1:0]                  energy_q [COMPONENTS];
  logic [sflv_pkg::STEP_W-1:0]    step_q;
  logic [KW-1:0]                  k_q;

  // item and working registers
  logic [3:0]                     ch_q;
  logic signed [15:0]             val_q;
  logic                           eoe_q;
  logic [sflv_pkg::SQ_W-1:0]      sq_q;
  logic [EW-1:0]                  quo_q;
  logic [15:0]                    rem_q;
  logic [5:0]                     cnt_q;
  logic [5:0]                     e_q;
  logic [sflv_pkg::MANT_W-1:0]    mant_q;
  logic signed [sflv_pkg::L2_W-1:0] l2_q;
  sflv_pkg::out_t                 out_q;

  // weight store
  logic signed [15:0] wmem [DEPTH];
  logic signed [15:0] rdata_q;
  logic [AW-1:0]      raddr;
  logic               wr_en;

  // shared multiplier
  logic signed [MW-1:0]                 mul_a, mul_b;
  logic signed [sflv_pkg::PROD_W-1:0]   prod;

  logic in_fire, out_fire, last_k, in_range, closes;
  logic [PW-1:0]        abs_p;
  logic [15:0]          ah;
  logic [19:0]          al;
  logic signed [PW:0]   proj_sum;
  logic [EW:0]          ener_sum;
  logic [16:0]          div_sh;
  logic [17:0]          div_diff;
  logic [EW-1:0]        var_w;
  logic [31:0]          sq_mant;
  logic [sflv_pkg::PROD_W-1:0] ln_mag;
  logic [sflv_pkg::PROD_W-1:0] ln_rnd;
  logic [23:0]          ln_r;

  assign nch = (ch_use_q == 5'd0) ? 7'd1 :
               ((7'(ch_use_q) > 7'(CHANNELS)) ? 7'(CHANNELS) : 7'(ch_use_q));
  assign ncomp = (comp_use_q == 4'd0) ? 5'd1 :
                 ((5'(comp_use_q) > 5'(COMPONENTS)) ? 5'(COMPONENTS) : 5'(comp_use_q));

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign last_k   = (5'(k_q) == ncomp - 5'd1);
  assign in_range = (7'(in_data_i.channel) < nch);
  assign closes   = (7'(ch_q) == nch - 7'd1);

  assign abs_p = proj_q[k_q][PW-1] ? PW'(-proj_q[k_q]) : PW'(proj_q[k_q]);
  assign ah    = abs_p[35:20];
  assign al    = abs_p[19:0];

  assign proj_sum = (PW+1)'(proj_q[k_q]) + (PW+1)'($signed(prod[31:0]));
  assign ener_sum = {1'b0, energy_q[k_q]} + (EW+1)'(sq_q);

  assign div_sh   = {rem_q, quo_q[EW-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, step_q};
  assign var_w    = (step_q == '0) ? '0 : quo_q;

  assign sq_mant  = prod[61:30];

  assign ln_mag = prod[sflv_pkg::PROD_W-1] ? sflv_pkg::PROD_W'(-prod) : sflv_pkg::PROD_W'(prod);
  assign ln_rnd = ln_mag + (sflv_pkg::PROD_W'(1) << 33);
  assign ln_r   = ln_rnd[57:34];

  // weight store
  assign wr_en = in_fire && (in_data_i.opcode == sflv_pkg::OP_WEIGHT) &&
                 (7'(in_data_i.channel) < 7'(CHANNELS)) &&
                 (5'(in_data_i.component) < 5'(COMPONENTS));
  assign raddr = {k_q, CW'(ch_q)};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[{KW'(in_data_i.component), CW'(in_data_i.channel)}] <= in_data_i.value;
    end
    rdata_q <= wmem[raddr];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      sflv_pkg::ST_MAC_MUL: begin
        mul_a = MW'(rdata_q);
        mul_b = MW'(val_q);
      end
      sflv_pkg::ST_SQ_HH: begin
        mul_a = MW'(ah);
        mul_b = MW'(ah);
      end
      sflv_pkg::ST_SQ_HL: begin
        mul_a = MW'(ah);
        mul_b = MW'(al);
      end
      sflv_pkg::ST_SQ_LL: begin
        mul_a = MW'(al);
        mul_b = MW'(al);
      end
      sflv_pkg::ST_LOG_MUL: begin
        mul_a = MW'(mant_q);
        mul_b = MW'(mant_q);
      end
      sflv_pkg::ST_LN_MUL: begin
        mul_a = MW'(l2_q);
        mul_b = sflv_pkg::LN2_Q30;
      end
      default: ;
    endcase
  end

  sflv_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sflv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = (state_q == sflv_pkg::ST_IDLE);
    out_valid_o = (state_q == sflv_pkg::ST_OUT);
    case (state_q)
      sflv_pkg::ST_IDLE: begin
        if (in_fire && (in_data_i.opcode == sflv_pkg::OP_SAMPLE)) begin
          if (in_range) state_d = sflv_pkg::ST_MAC_RD;
          else if (in_data_i.end_of_epoch) state_d = sflv_pkg::ST_FEAT;
        end
      end
      sflv_pkg::ST_MAC_RD:  state_d = sflv_pkg::ST_MAC_MUL;
      sflv_pkg::ST_MAC_MUL: state_d = sflv_pkg::ST_MAC_ACC;
      sflv_pkg::ST_MAC_ACC: begin
        if (!last_k) state_d = sflv_pkg::ST_MAC_RD;
        else if (closes) state_d = sflv_pkg::ST_SQ_HH;
        else if (eoe_q) state_d = sflv_pkg::ST_FEAT;
        else state_d = sflv_pkg::ST_IDLE;
      end
      sflv_pkg::ST_SQ_HH:  state_d = sflv_pkg::ST_SQ_HL;
      sflv_pkg::ST_SQ_HL:  state_d = sflv_pkg::ST_SQ_LL;
      sflv_pkg::ST_SQ_LL:  state_d = sflv_pkg::ST_SQ_ADD;
      sflv_pkg::ST_SQ_ADD: state_d = sflv_pkg::ST_ENERGY;
      sflv_pkg::ST_ENERGY: begin
        if (!last_k) state_d = sflv_pkg::ST_SQ_HH;
        else if (eoe_q) state_d = sflv_pkg::ST_FEAT;
        else state_d = sflv_pkg::ST_IDLE;
      end
      sflv_pkg::ST_FEAT: state_d = sflv_pkg::ST_DIV;
      sflv_pkg::ST_DIV: begin
        if (cnt_q == 6'd63) state_d = sflv_pkg::ST_SEL;
      end
      sflv_pkg::ST_SEL:  state_d = use_log_q ? sflv_pkg::ST_NORM : sflv_pkg::ST_OUT;
      sflv_pkg::ST_NORM: begin
        if (quo_q[EW-1]) state_d = sflv_pkg::ST_LOG_MUL;
      end
      sflv_pkg::ST_LOG_MUL: state_d = sflv_pkg::ST_LOG_UPD;
      sflv_pkg::ST_LOG_UPD: begin
        state_d = (cnt_q == '0) ? sflv_pkg::ST_LN_MUL : sflv_pkg::ST_LOG_MUL;
      end
      sflv_pkg::ST_LN_MUL: state_d = sflv_pkg::ST_LN_RND;
      sflv_pkg::ST_LN_RND: state_d = sflv_pkg::ST_OUT;
      sflv_pkg::ST_OUT: begin
        if (out_fire) state_d = last_k ? sflv_pkg::ST_IDLE : sflv_pkg::ST_FEAT;
      end
      default: state_d = sflv_pkg::ST_IDLE;
    endcase
  end

  // configuration and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_log_q  <= 1'b1;
      ch_use_q   <= 5'd16;
      comp_use_q <= 4'd8;
      step_q     <= '0;
      k_q        <= '0;
      for (int i = 0; i < COMPONENTS; i++) begin
        proj_q[i]   <= '0;
        energy_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sflv_pkg::CFG_USE_LOG:    use_log_q  <= cfg_wdata_i[0];
          sflv_pkg::CFG_CHANNELS:   ch_use_q   <= cfg_wdata_i;
          sflv_pkg::CFG_COMPONENTS: comp_use_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      case (state_q)
        sflv_pkg::ST_IDLE: begin
          if (in_fire) k_q <= '0;
        end
        sflv_pkg::ST_MAC_ACC: begin
          // saturate to the 36-bit projection range
          if (proj_sum[PW] != proj_sum[PW-1]) begin
            proj_q[k_q] <= proj_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
          end else begin
            proj_q[k_q] <= proj_sum[PW-1:0];
          end
          k_q <= last_k ? '0 : k_q + KW'(1);
        end
        sflv_pkg::ST_ENERGY: begin
          energy_q[k_q] <= ener_sum[EW] ? {EW{1'b1}} : ener_sum[EW-1:0];
          proj_q[k_q]   <= '0;
          if (last_k) begin
            k_q <= '0;
            if (step_q != {sflv_pkg::STEP_W{1'b1}}) step_q <= step_q + sflv_pkg::STEP_W'(1);
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        sflv_pkg::ST_OUT: begin
          if (out_fire) begin
            if (last_k) begin
              step_q <= '0;
              for (int i = 0; i < COMPONENTS; i++) begin
                proj_q[i]   <= '0;
                energy_q[i] <= '0;
              end
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      sflv_pkg::ST_IDLE: begin
        if (in_fire) begin
          ch_q  <= in_data_i.channel;
          val_q <= in_data_i.value;
          eoe_q <= in_data_i.end_of_epoch;
        end
      end
      sflv_pkg::ST_SQ_HL:  sq_q <= {prod[30:0], 24'd0};
      sflv_pkg::ST_SQ_LL:  sq_q <= sq_q + sflv_pkg::SQ_W'({prod[35:0], 5'd0});
      sflv_pkg::ST_SQ_ADD: sq_q <= sq_q + sflv_pkg::SQ_W'(prod[39:16]);
      sflv_pkg::ST_FEAT: begin
        quo_q <= energy_q[k_q];
        rem_q <= '0;
        cnt_q <= '0;
      end
      sflv_pkg::ST_DIV: begin
        // one quotient bit per cycle
        if (!div_diff[17]) begin
          rem_q <= div_diff[15:0];
          quo_q <= {quo_q[EW-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[15:0];
          quo_q <= {quo_q[EW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
      end
      sflv_pkg::ST_SEL: begin
        out_q.component_index <= 3'(k_q);
        out_q.last            <= last_k;
        out_q.feature <= (|var_w[EW-1:sflv_pkg::FEAT_W-1]) ?
                         {1'b0, {(sflv_pkg::FEAT_W-1){1'b1}}} : var_w[sflv_pkg::FEAT_W-1:0];
        // floor the variance to one LSB before the log
        quo_q <= (var_w == '0) ? EW'(1) : var_w;
        e_q   <= 6'd63;
      end
      sflv_pkg::ST_NORM: begin
        if (quo_q[EW-1]) begin
          mant_q <= quo_q[EW-1:EW-sflv_pkg::MANT_W];
          l2_q   <= {7'(e_q) - 7'd12, 20'd0};
          cnt_q  <= sflv_pkg::LOG_FRAC_TOP;
        end else begin
          quo_q <= {quo_q[EW-2:0], 1'b0};
          e_q   <= e_q - 6'd1;
        end
      end
      sflv_pkg::ST_LOG_UPD: begin
        if (sq_mant[31]) begin
          mant_q <= sq_mant[31:1];
          l2_q   <= l2_q | (sflv_pkg::L2_W'(1) << cnt_q);
        end else begin
          mant_q <= sq_mant[30:0];
        end
        cnt_q <= cnt_q - 6'd1;
      end
      sflv_pkg::ST_LN_RND: begin
        out_q.feature <= prod[sflv_pkg::PROD_W-1] ?
                         -sflv_pkg::FEAT_W'(ln_r) : sflv_pkg::FEAT_W'(ln_r);
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

@@ src/sflv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflv_checker
// Port-level checks of the feature block, bound to the top level.
// ----------------------------------------------------------------------------
module sflv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input sflv_pkg::in_t                    in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input sflv_pkg::out_t                   out_data_o,
  input logic                             cfg_we_i,
  input logic [sflv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [sflv_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // a result is never shown while an item can be taken
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and result valid together");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // after the final feature of an epoch the block returns to accepting
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o && !out_valid_o)
    else $error("no return to idle after last feature");

  // a weight load completes in its own cycle
  a_wload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == sflv_pkg::OP_WEIGHT) |=> in_ready_o)
    else $error("weight load stalled the input");

endmodule

bind spatial_filter_log_variance_features sflv_checker u_sflv_checker (.*);

@@ verif/sflv_feature_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflv_feature_checker
// Watches the item, feature and register ports of the feature block, keeps
// its own copy of weights, projections, energies and step count, predicts
// the features of every epoch end and compares them in order.
// ----------------------------------------------------------------------------
module sflv_feature_checker
  import sflv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    err_count_o,
  output int                    pending_o
);

  localparam longint PROJ_HI = 64'sd34359738367;
  localparam longint PROJ_LO = -64'sd34359738368;
  localparam logic [63:0] VAR_HI = 64'd140737488355327;

  logic signed [15:0] weight_mem [CHANNELS_DEF][COMPONENTS_DEF];
  longint             proj_acc [COMPONENTS_DEF];
  logic [63:0]        energy_acc [COMPONENTS_DEF];
  logic [15:0]        steps;
  logic               log_mode;
  logic [4:0]         chan_reg;
  logic [3:0]         comp_reg;
  out_t               features_due [$];

  // ln(v / 2^12) in Q8.16 through a 20-bit squaring log2
  function automatic longint ln_q8_16(logic [63:0] v);
    int          msb;
    logic [63:0] mant;
    longint      l2, prod, mag, r;
    msb = 63;
    while (msb > 0 && !v[msb]) msb--;
    mant = (msb >= 30) ? (v >> (msb - 30)) : (v << (30 - msb));
    l2 = longint'(msb - 12) * 64'sd1048576;
    for (int i = 19; i >= 0; i--) begin
      mant = (mant * mant) >> 30;
      if (mant >= 64'h8000_0000) begin
        mant = mant >> 1;
        l2 += 64'sd1 <<< i;
      end
    end
    prod = l2 * 64'sd744261118;
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (64'sd1 <<< 33)) >>> 34;
    return (prod < 0) ? -r : r;
  endfunction

  task automatic absorb_item(in_t it);
    int          nch, ncomp;
    longint      s;
    logic [71:0] sq, mag;
    logic [64:0] esum;
    logic [63:0] variance;
    out_t        f;
    nch   = (chan_reg == 0) ? 1 : (chan_reg > CHANNELS_DEF) ? CHANNELS_DEF : chan_reg;
    ncomp = (comp_reg == 0) ? 1 : (comp_reg > COMPONENTS_DEF) ? COMPONENTS_DEF : comp_reg;
    if (it.opcode == OP_WEIGHT) begin
      weight_mem[it.channel][it.component] = it.value;
      return;
    end
    if (it.channel < nch) begin
      for (int k = 0; k < ncomp; k++) begin
        s = proj_acc[k] + longint'(weight_mem[it.channel][k]) * longint'(it.value);
        if (s > PROJ_HI) s = PROJ_HI;
        if (s < PROJ_LO) s = PROJ_LO;
        proj_acc[k] = s;
      end
      if (it.channel == nch - 1) begin
        for (int k = 0; k < ncomp; k++) begin
          mag  = (proj_acc[k] < 0) ? 72'(-proj_acc[k]) : 72'(proj_acc[k]);
          sq   = (mag * mag) >> 16;
          esum = {1'b0, energy_acc[k]} + sq[64:0];
          energy_acc[k] = esum[64] ? '1 : esum[63:0];
          proj_acc[k] = 0;
        end
        if (steps != 16'hFFFF) steps++;
      end
    end
    if (it.end_of_epoch) begin
      for (int k = 0; k < ncomp; k++) begin
        variance = (steps != 0) ? energy_acc[k] / steps : 64'd0;
        f.component_index = 3'(k);
        f.last = (k == ncomp - 1);
        if (log_mode) begin
          if (variance == 0) variance = 1;
          f.feature = 48'(ln_q8_16(variance));
        end else begin
          f.feature = (variance > VAR_HI) ? VAR_HI[47:0] : variance[47:0];
        end
        features_due.insert(features_due.size(), f);
      end
      for (int k = 0; k < COMPONENTS_DEF; k++) begin
        proj_acc[k] = 0;
        energy_acc[k] = '0;
      end
      steps = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < COMPONENTS_DEF; k++) begin
        proj_acc[k] = 0;
        energy_acc[k] = '0;
      end
      steps = '0;
      log_mode = 1'b1;
      chan_reg = 5'd16;
      comp_reg = 4'd8;
      features_due.delete();
      err_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (features_due.size() == 0) begin
          $error("feature transaction with nothing expected: idx %0d feature %0d",
                 out_data_i.component_index, out_data_i.feature);
          err_count_o++;
        end else begin
          want = features_due.pop_front();
          if (out_data_i.component_index !== want.component_index) begin
            $error("component_index: expected %0d, got %0d",
                   want.component_index, out_data_i.component_index);
            err_count_o++;
          end
          if (out_data_i.feature !== want.feature) begin
            $error("feature: expected %0d, got %0d", want.feature, out_data_i.feature);
            err_count_o++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data_i.last);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_item(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_USE_LOG:    log_mode = cfg_wdata_i[0];
          CFG_CHANNELS:   chan_reg = cfg_wdata_i;
          CFG_COMPONENTS: comp_reg = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
    pending_o = features_due.size();
  end

endmodule

@@ verif/tb_spatial_filter_log_variance_features.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spatial_filter_log_variance_features
// Loads the filter weights that the register settings reach, runs directed
// extreme and empty epochs, then random epochs under several register
// settings with random stalls on both channels. The checker predicts and
// compares; this top drives and decides.
// ----------------------------------------------------------------------------
module tb_spatial_filter_log_variance_features;
  import sflv_pkg::*;

  localparam int SEGMENTS = 8;
  localparam int STALL_LIMIT = 20000;

  // per segment, segment 0 in the lowest slot; a setting either uses at most
  // four channels or at most two components, so only loaded weights are read
  localparam logic [SEGMENTS-1:0] LOG_SET = 8'b0101_0101;
  localparam logic [SEGMENTS-1:0][4:0] CHAN_SET =
    {5'd2, 5'd17, 5'd4, 5'd3, 5'd0, 5'd1, 5'd4, 5'd8};
  localparam logic [SEGMENTS-1:0][4:0] COMP_SET =
    {5'd9, 5'd1, 5'd3, 5'd15, 5'd0, 5'd1, 5'd8, 5'd2};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    err_count, pending;
  int                    send_idle_pct, recv_idle_pct;
  int                    active_chans;
  int                    stall_cycles;

  spatial_filter_log_variance_features u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  sflv_feature_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_sample(int chan, logic [15:0] val, logic eoe);
    in_t it;
    it.opcode = OP_SAMPLE;
    it.channel = 4'(chan);
    it.component = 3'($urandom_range(7));
    it.value = val;
    it.end_of_epoch = eoe;
    send_item(it);
  endtask

  task automatic send_weight(int chan, int comp, logic [15:0] val);
    in_t it;
    it.opcode = OP_WEIGHT;
    it.channel = 4'(chan);
    it.component = 3'(comp);
    it.value = val;
    it.end_of_epoch = 1'($urandom_range(1));
    send_item(it);
  endtask

  // hold the item channel until every feature has been taken
  task automatic drain_features(int extra);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly whole steps; sometimes stray channels, partial steps or early ends
  task automatic run_epoch(ref int sent);
    int nsteps;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        send_sample($urandom_range(15), pick_value(), 1'($urandom_range(3) == 0));
        sent++;
      end
      send_sample($urandom_range(15), pick_value(), 1'b1);
      sent++;
    end else begin
      nsteps = $urandom_range(1, (active_chans > 4) ? 1 : 3);
      for (int s = 0; s < nsteps; s++) begin
        for (int c = 0; c < active_chans; c++) begin
          if ($urandom_range(15) == 0)
            send_weight($urandom_range(15), $urandom_range(7), pick_value());
          send_sample(c, pick_value(), (s == nsteps - 1) && (c == active_chans - 1));
          sent++;
        end
      end
    end
    if ($urandom_range(3) == 0) drain_features(0);
  endtask

  initial begin
    int sent;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    send_idle_pct = 31;
    recv_idle_pct = 51;
    active_chans = 16;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // component 0 at the negative extreme, 1 at the positive, rest random;
    // components above 1 only on the first four channels
    for (int k = 0; k < COMPONENTS_DEF; k++)
      for (int c = 0; c < CHANNELS_DEF; c++)
        if (k < 2 || c < 4)
          send_weight(c, k, (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : pick_value());

    // all sixteen channels on the two extreme components
    drain_features(0);
    write_reg(CFG_COMPONENTS, 5'd2);

    // empty epoch: end on a partial step
    send_sample(0, 16'h1234, 1'b1);
    // largest projection, log mode
    for (int c = 0; c < 16; c++) send_sample(c, 16'h8000, c == 15);
    drain_features(100);
    write_reg(CFG_USE_LOG, 5'd0);
    // largest projection, variance mode saturates
    for (int c = 0; c < 16; c++) send_sample(c, 16'h8000, c == 15);
    send_sample(3, 16'h0000, 1'b1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_features(100);
      if (seg == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 31;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_USE_LOG, {4'd0, LOG_SET[seg]});
      write_reg(CFG_CHANNELS, CHAN_SET[seg]);
      write_reg(CFG_COMPONENTS, COMP_SET[seg]);
      active_chans = (CHAN_SET[seg] == 0) ? 1 : (CHAN_SET[seg] > 16) ? 16 : CHAN_SET[seg];
      sent = 0;
      while (sent < 8) run_epoch(sent);
    end

    drain_features(200);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
